/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/core/psra_pkg.sv */
// Package for the per-sensor running-average alarm: sizes, codes and the
// transaction and control structs. No dependencies.
package psra_pkg;

    localparam int SENSORS    = 16;
    localparam int WINDOW_LEN = 5;

    localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int CNT_W  = $clog2(SENSORS + 1);
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int MAG_W  = 16 + FILL_W;
    localparam int SUM_W  = MAG_W + 1;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = CFG_IDX_W'(1);

    localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd6400;
    localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd3840;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] STAT_LOADED  = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_UNKNOWN = 3'd2;
    localparam logic [2:0] STAT_WARMING = 3'd3;
    localparam logic [2:0] STAT_NORMAL  = 3'd4;
    localparam logic [2:0] STAT_HOT     = 3'd5;
    localparam logic [2:0] STAT_COLD    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        probe_id;
        logic [15:0]        room_id;
        logic signed [15:0] temperature;
        logic [31:0]        timestamp;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        sensor_out;
        logic [15:0]        room_out;
        logic signed [15:0] running_avg;
        logic [31:0]        last_seen;
        logic [CNT_W-1:0]   sensors_loaded;
    } rsp_t;

    typedef struct packed {
        logic             srch_start;
        logic [15:0]      srch_id;
        logic             wr;
        logic             wr_new;
        logic [IDX_W-1:0] wr_idx;
        logic [15:0]      wr_id;
        logic [15:0]      wr_room;
    } map_ctrl_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic [15:0]      room;
        logic [CNT_W-1:0] count;
    } map_stat_t;

    typedef struct packed {
        logic               clear;
        logic               write;
        logic               sum_start;
        logic [IDX_W-1:0]   entry;
        logic signed [15:0] temp;
    } win_ctrl_t;

    typedef struct packed {
        logic               will_fill;
        logic               done;
        logic signed [15:0] mean;
    } win_stat_t;

endpackage

/* rtl/core/psra_map.sv */
// Sensor map: id and room tables, valid bits, entry count and a walker that
// compares one entry per cycle. Depends on psra_pkg.
module psra_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psra_pkg::map_ctrl_t   ctrl,
    output psra_pkg::map_stat_t   stat
);

    localparam logic [psra_pkg::IDX_W-1:0] LAST_IDX =
        psra_pkg::IDX_W'(psra_pkg::SENSORS - 1);

    logic [15:0]                id_tbl_reg   [psra_pkg::SENSORS];
    logic [15:0]                room_tbl_reg [psra_pkg::SENSORS];
    logic                       valid_reg    [psra_pkg::SENSORS];
    logic [psra_pkg::CNT_W-1:0] count_reg;

    logic                       busy_reg;
    logic                       done_reg;
    logic [psra_pkg::IDX_W-1:0] idx_reg;
    logic [15:0]                key_reg;
    logic                       hit_reg;
    logic [psra_pkg::IDX_W-1:0] hit_idx_reg;
    logic                       free_ok_reg;
    logic [psra_pkg::IDX_W-1:0] free_idx_reg;

    logic cur_valid;
    logic cur_match;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_match = cur_valid && (id_tbl_reg[idx_reg] == key_reg);

    // Walk the table once per search; keep the first match and first free slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (idx_reg == LAST_IDX);
            if (ctrl.srch_start)
            begin
                busy_reg    <= 1'b1;
                idx_reg     <= '0;
                hit_reg     <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (cur_match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= idx_reg;
                end
                if (!cur_valid && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.srch_start)
        begin
            key_reg <= ctrl.srch_id;
        end
        if (ctrl.wr)
        begin
            id_tbl_reg[ctrl.wr_idx]   <= ctrl.wr_id;
            room_tbl_reg[ctrl.wr_idx] <= ctrl.wr_room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psra_pkg::SENSORS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            count_reg <= '0;
        end
        else if (ctrl.wr)
        begin
            valid_reg[ctrl.wr_idx] <= 1'b1;
            if (ctrl.wr_new)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.done     = done_reg;
        stat.hit      = hit_reg;
        stat.hit_idx  = hit_idx_reg;
        stat.free_ok  = free_ok_reg;
        stat.free_idx = free_idx_reg;
        stat.room     = room_tbl_reg[hit_idx_reg];
        stat.count    = count_reg;
    end

endmodule

/* rtl/core/psra_window.sv */
// Sample windows: per-sensor sample memory, fill and slot counters, and a
// shared accumulator with a reciprocal-multiply divide. Depends on psra_pkg.
module psra_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psra_pkg::win_ctrl_t   ctrl,
    output psra_pkg::win_stat_t   stat
);

    localparam int DEPTH     = psra_pkg::SENSORS * psra_pkg::WINDOW_LEN;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIV_SHIFT = psra_pkg::MAG_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = psra_pkg::MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(psra_pkg::WINDOW_LEN) - 64'd1)
        / 64'(psra_pkg::WINDOW_LEN));
    localparam logic [psra_pkg::SLOT_W-1:0] LAST_SLOT =
        psra_pkg::SLOT_W'(psra_pkg::WINDOW_LEN - 1);
    localparam logic [psra_pkg::FILL_W-1:0] FULL_FILL =
        psra_pkg::FILL_W'(psra_pkg::WINDOW_LEN);
    localparam logic [psra_pkg::FILL_W-1:0] LAST_FILL =
        psra_pkg::FILL_W'(psra_pkg::WINDOW_LEN - 1);

    logic [15:0]                 win_mem  [DEPTH];
    logic [psra_pkg::FILL_W-1:0] fill_reg [psra_pkg::SENSORS];
    logic [psra_pkg::SLOT_W-1:0] slot_reg [psra_pkg::SENSORS];

    logic                        busy_reg;
    logic [psra_pkg::SLOT_W-1:0] k_reg;
    logic [psra_pkg::IDX_W-1:0]  base_reg;
    logic [15:0]                 rd_data_reg;
    logic                        rd_v_reg;
    logic                        rd_last_reg;
    logic [psra_pkg::SUM_W-1:0]  acc_reg;
    logic                        acc_done_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        neg_reg;
    logic                        prod_v_reg;
    logic signed [15:0]          mean_reg;
    logic                        done_reg;

    logic [psra_pkg::SLOT_W-1:0] cur_slot;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [psra_pkg::SUM_W-1:0]  acc_neg;
    logic [psra_pkg::MAG_W-1:0]  mag;
    logic [16:0]                 quot;
    logic [16:0]                 quot_neg;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [psra_pkg::IDX_W-1:0]  idx,
        input logic [psra_pkg::SLOT_W-1:0] off
    );
        addr_of = ADDR_W'(idx) * ADDR_W'(psra_pkg::WINDOW_LEN) + ADDR_W'(off);
    endfunction

    assign cur_slot = slot_reg[ctrl.entry];
    assign wr_addr  = addr_of(ctrl.entry, cur_slot);
    assign rd_addr  = addr_of(base_reg, k_reg);
    assign acc_neg  = ~acc_reg + 1'b1;
    assign mag      = acc_reg[psra_pkg::SUM_W-1] ? acc_neg[psra_pkg::MAG_W-1:0]
                                                 : acc_reg[psra_pkg::MAG_W-1:0];
    assign quot     = prod_reg[DIV_SHIFT +: 17];
    assign quot_neg = ~quot + 1'b1;

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            win_mem[wr_addr] <= ctrl.temp;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psra_pkg::SENSORS; i++)
            begin
                fill_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            fill_reg[ctrl.entry] <= '0;
            slot_reg[ctrl.entry] <= '0;
        end
        else if (ctrl.write)
        begin
            slot_reg[ctrl.entry] <= (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
            if (fill_reg[ctrl.entry] != FULL_FILL)
            begin
                fill_reg[ctrl.entry] <= fill_reg[ctrl.entry] + 1'b1;
            end
        end
    end

    // Read sequencer, accumulate, then multiply by the reciprocal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            rd_v_reg     <= 1'b0;
            rd_last_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
            prod_v_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= busy_reg;
            rd_last_reg  <= busy_reg && (k_reg == LAST_SLOT);
            acc_done_reg <= rd_v_reg && rd_last_reg;
            prod_v_reg   <= acc_done_reg;
            done_reg     <= prod_v_reg;
            if (ctrl.sum_start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (k_reg == LAST_SLOT)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_start)
        begin
            base_reg <= ctrl.entry;
            acc_reg  <= '0;
        end
        else if (rd_v_reg)
        begin
            acc_reg <= acc_reg + {{(psra_pkg::SUM_W-16){rd_data_reg[15]}}, rd_data_reg};
        end
        if (acc_done_reg)
        begin
            prod_reg <= PROD_W'(mag) * PROD_W'(RECIP);
            neg_reg  <= acc_reg[psra_pkg::SUM_W-1];
        end
        if (prod_v_reg)
        begin
            mean_reg <= neg_reg ? quot_neg[15:0] : quot[15:0];
        end
    end

    always_comb
    begin
        stat.will_fill = (fill_reg[ctrl.entry] >= LAST_FILL);
        stat.done      = done_reg;
        stat.mean      = mean_reg;
    end

endmodule

/* rtl/core/per_sensor_running_average_alarm.sv */
// Top level of the per-sensor running-average alarm: sequencer, threshold
// registers and result register. Depends on psra_pkg, psra_map, psra_window.
//
//  channel  | handshake          | payload                 | direction
//  ---------+--------------------+-------------------------+----------
//  req      | req_valid/req_stall| psra_pkg::req_t         | in
//  rsp      | rsp_valid/rsp_stall| psra_pkg::rsp_t         | out
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data     | in
//
// One transaction at a time. The map walker compares one table entry per
// cycle. A load or a warming sample goes through the search and apply states
// to the result; an unknown sensor or a full table skips the apply state. A
// full-window sample also passes through the sum state: WINDOW_LEN memory
// reads through the shared accumulator plus the divide stages.
// Reset clears valid bits, counters and the sequencer at once; no clearing pass.
// The result register holds a transaction while rsp_stall is high; the block
// takes the next request meanwhile and waits only if a new result is ready.
// Configuration writes are taken in any cycle.
module per_sensor_running_average_alarm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  psra_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output psra_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);

    psra_pkg::state_t   state_reg;
    psra_pkg::state_t   state_next;

    psra_pkg::req_t     req_reg;
    logic [2:0]         stat_reg;
    logic [2:0]         stat_next;
    logic               stat_load;
    logic               req_load;
    logic               rsp_load;
    logic               rsp_valid_reg;
    psra_pkg::rsp_t     rsp_reg;
    psra_pkg::rsp_t     rsp_next;
    logic signed [15:0] max_temp_reg;
    logic signed [15:0] min_temp_reg;

    psra_pkg::map_ctrl_t map_ctrl;
    psra_pkg::map_stat_t map_stat;
    psra_pkg::win_ctrl_t win_ctrl;
    psra_pkg::win_stat_t win_stat;

    logic                       is_load;
    logic [psra_pkg::IDX_W-1:0] load_idx;

    assign is_load  = (req_reg.opcode == psra_pkg::OP_LOAD);
    // Reuse the matching entry on a repeated id, else take the first free one.
    assign load_idx = map_stat.hit ? map_stat.hit_idx : map_stat.free_idx;

    psra_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (map_ctrl),
        .stat  (map_stat)
    );

    psra_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (win_ctrl),
        .stat  (win_stat)
    );

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psra_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = psra_pkg::ST_SEARCH;
                end
            end
            psra_pkg::ST_SEARCH:
            begin
                if (map_stat.done)
                begin
                    if (is_load)
                    begin
                        state_next = (map_stat.hit || map_stat.free_ok)
                                     ? psra_pkg::ST_APPLY : psra_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = map_stat.hit ? psra_pkg::ST_APPLY
                                                  : psra_pkg::ST_EMIT;
                    end
                end
            end
            psra_pkg::ST_APPLY:
            begin
                state_next = (!is_load && win_stat.will_fill) ? psra_pkg::ST_SUM
                                                              : psra_pkg::ST_EMIT;
            end
            psra_pkg::ST_SUM:
            begin
                if (win_stat.done)
                begin
                    state_next = psra_pkg::ST_EMIT;
                end
            end
            psra_pkg::ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = psra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psra_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: commands to the map and window units, status capture.
    always_comb
    begin
        req_load  = 1'b0;
        rsp_load  = 1'b0;
        stat_load = 1'b0;
        stat_next = psra_pkg::STAT_LOADED;

        map_ctrl.srch_start = 1'b0;
        map_ctrl.srch_id    = req.probe_id;
        map_ctrl.wr         = 1'b0;
        map_ctrl.wr_new     = !map_stat.hit;
        map_ctrl.wr_idx     = load_idx;
        map_ctrl.wr_id      = req_reg.probe_id;
        map_ctrl.wr_room    = req_reg.room_id;

        win_ctrl.clear     = 1'b0;
        win_ctrl.write     = 1'b0;
        win_ctrl.sum_start = 1'b0;
        win_ctrl.entry     = is_load ? load_idx : map_stat.hit_idx;
        win_ctrl.temp      = req_reg.temperature;

        case (state_reg)
            psra_pkg::ST_IDLE:
            begin
                req_load            = req_valid;
                map_ctrl.srch_start = req_valid;
            end
            psra_pkg::ST_SEARCH:
            begin
                if (map_stat.done)
                begin
                    // Table full on a load of a new id, or unknown id on a sample.
                    if (is_load && !map_stat.hit && !map_stat.free_ok)
                    begin
                        stat_load = 1'b1;
                        stat_next = psra_pkg::STAT_FULL;
                    end
                    else if (!is_load && !map_stat.hit)
                    begin
                        stat_load = 1'b1;
                        stat_next = psra_pkg::STAT_UNKNOWN;
                    end
                end
            end
            psra_pkg::ST_APPLY:
            begin
                if (is_load)
                begin
                    map_ctrl.wr    = 1'b1;
                    win_ctrl.clear = 1'b1;
                    stat_load      = 1'b1;
                    stat_next      = psra_pkg::STAT_LOADED;
                end
                else
                begin
                    win_ctrl.write = 1'b1;
                    if (win_stat.will_fill)
                    begin
                        win_ctrl.sum_start = 1'b1;
                    end
                    else
                    begin
                        stat_load = 1'b1;
                        stat_next = psra_pkg::STAT_WARMING;
                    end
                end
            end
            psra_pkg::ST_SUM:
            begin
                if (win_stat.done)
                begin
                    stat_load = 1'b1;
                    if (win_stat.mean > max_temp_reg)
                    begin
                        stat_next = psra_pkg::STAT_HOT;
                    end
                    else if (win_stat.mean < min_temp_reg)
                    begin
                        stat_next = psra_pkg::STAT_COLD;
                    end
                    else
                    begin
                        stat_next = psra_pkg::STAT_NORMAL;
                    end
                end
            end
            psra_pkg::ST_EMIT:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_load = 1'b0;
            end
        endcase
    end

    // Hold the accepted request and the status until the result is built.
    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            req_reg <= req;
        end
        if (stat_load)
        begin
            stat_reg <= stat_next;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Assemble the result; zero the fields that the status leaves undefined.
    always_comb
    begin
        rsp_next.status         = stat_reg;
        rsp_next.sensor_out     = req_reg.probe_id;
        rsp_next.sensors_loaded = map_stat.count;
        rsp_next.room_out       = '0;
        rsp_next.running_avg    = '0;
        rsp_next.last_seen      = '0;
        if (stat_reg == psra_pkg::STAT_LOADED)
        begin
            rsp_next.room_out = req_reg.room_id;
        end
        if (stat_reg inside {psra_pkg::STAT_WARMING, psra_pkg::STAT_NORMAL,
                             psra_pkg::STAT_HOT, psra_pkg::STAT_COLD})
        begin
            rsp_next.room_out  = map_stat.room;
            rsp_next.last_seen = req_reg.timestamp;
        end
        if (stat_reg inside {psra_pkg::STAT_NORMAL, psra_pkg::STAT_HOT,
                             psra_pkg::STAT_COLD})
        begin
            rsp_next.running_avg = win_stat.mean;
        end
    end

    // Result register: drop valid once the transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Threshold registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg <= psra_pkg::MAX_TEMP_RESET;
            min_temp_reg <= psra_pkg::MIN_TEMP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psra_pkg::CFG_MAX_TEMP: max_temp_reg <= cfg_data;
                psra_pkg::CFG_MIN_TEMP: min_temp_reg <= cfg_data;
                default:                max_temp_reg <= max_temp_reg;
            endcase
        end
    end

    assign req_stall = (state_reg != psra_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

/* rtl/core/psra_checker.sv */
// Port-level checks for the per-sensor running-average alarm, bound to the
// top level. Depends on psra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psra_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_stall,
    input  logic                              rsp_valid,
    input  logic                              rsp_stall,
    input  psra_pkg::rsp_t                    rsp
);

    localparam logic [psra_pkg::CNT_W-1:0] MAX_LOADED = psra_pkg::CNT_W'(psra_pkg::SENSORS);

    logic req_taken;
    logic plain_rsp;
    logic no_extras;
    logic full_rsp;
    logic rsp_held;

    assign req_taken = req_valid && !req_stall;
    assign plain_rsp = rsp_valid && (rsp.status == psra_pkg::STAT_LOADED ||
                                     rsp.status == psra_pkg::STAT_FULL ||
                                     rsp.status == psra_pkg::STAT_UNKNOWN);
    assign no_extras = (rsp.running_avg == 16'sd0) && (rsp.last_seen == 32'd0);
    assign full_rsp  = rsp_valid && (rsp.status == psra_pkg::STAT_FULL);
    assign rsp_held  = rsp_valid && rsp_stall;

    // A request occupies the block: the next cycle must stall.
    `ASSERT_NEXT(a_busy_after_accept, req_taken, req_stall, "accepted request not held off")

    // Load, full-table and unknown-sensor results carry no average and no timestamp.
    `ASSERT_SAME(a_zero_fields, plain_rsp, no_extras, "load or miss result has extra fields")

    // A full table is reported only when every entry is held.
    `ASSERT_SAME(a_full_count, full_rsp, rsp.sensors_loaded == MAX_LOADED, "full below capacity")

    // A stalled result holds.
    `ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind per_sensor_running_average_alarm psra_checker u_psra_checker (.*);
